/* rtl/odd_even_transposition_sort_defines.svh */
// ----------------------------------------------------------------------------
// Odd-even transposition sorter assertion macros
// Concurrent check wrappers, compiled out when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ODD_EVEN_TRANSPOSITION_SORT_DEFINES_SVH
`define ODD_EVEN_TRANSPOSITION_SORT_DEFINES_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define OETS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: lbl");
// prop must never hold outside reset
`define OETS_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition: lbl");
`else
`define OETS_ASSERT(lbl, clk, rst_n, prop)
`define OETS_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

/* rtl/oets_pkg.sv */
// ----------------------------------------------------------------------------
// Odd-even transposition sorter package
// Widths, cell operations and the signed compare shared by the modules and interfaces.
// ----------------------------------------------------------------------------
package oets_pkg;

  localparam int unsigned MAX_ELEMENTS = 64;
  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned COUNT_W      = $clog2(MAX_ELEMENTS + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [COUNT_W-1:0]            count_t;

  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_LOAD   = 2'd1,
    CELL_UNLOAD = 2'd2,
    CELL_CMP    = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     use_right;
  } cell_ctrl_t;

  // empty entries rank above every value
  function automatic logic greater(input logic a_valid, input value_t a,
                                   input logic b_valid, input value_t b);
    logic res;
    if (!a_valid) begin
      res = b_valid;
    end else if (!b_valid) begin
      res = 1'b0;
    end else begin
      res = (a > b);
    end
    return res;
  endfunction

endpackage

/* rtl/oets_in_if.sv */
// ----------------------------------------------------------------------------
// Sorter input channel
// Valid/ready channel carrying one element and its last mark per beat.
// ----------------------------------------------------------------------------
interface oets_in_if import oets_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

/* rtl/oets_out_if.sv */
// ----------------------------------------------------------------------------
// Sorter output channel
// Valid/ready channel carrying one sorted element and its flags per beat.
// ----------------------------------------------------------------------------
interface oets_out_if import oets_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   end_of_run;
  logic   dropped;

  modport source (output valid, output sorted_value, output end_of_run,
                  output dropped, input ready);
  modport sink   (input valid, input sorted_value, input end_of_run,
                  input dropped, output ready);
endinterface

/* rtl/oets_cell.sv */
// ----------------------------------------------------------------------------
// Sorter cell
// Holds one element; shifts with its neighbors or does a compare-exchange.
// ----------------------------------------------------------------------------
module oets_cell import oets_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       left_valid_i,
  input  value_t     left_value_i,
  input  logic       right_valid_i,
  input  value_t     right_value_i,
  output logic       valid_o,
  output value_t     value_o
);

  logic   valid_q, valid_d;
  value_t value_q, value_d;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    case (ctrl_i.op)
      CELL_LOAD: begin
        valid_d = left_valid_i;
        value_d = left_value_i;
      end
      CELL_UNLOAD: begin
        valid_d = right_valid_i;
        value_d = right_value_i;
      end
      CELL_CMP: begin
        if (ctrl_i.use_right) begin
          // keep the smaller of the pair
          if (greater(valid_q, value_q, right_valid_i, right_value_i)) begin
            valid_d = right_valid_i;
            value_d = right_value_i;
          end
        end else begin
          // keep the larger of the pair
          if (greater(left_valid_i, left_value_i, valid_q, value_q)) begin
            valid_d = left_valid_i;
            value_d = left_value_i;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

/* rtl/odd_even_transposition_sort.sv */
// ----------------------------------------------------------------------------
// Odd-even transposition sorter
// Loads a set into a chain of cells, sorts it in place, shifts it out.
//
//   channel  dir  payload                              beat
//   in_i     in   value, is_last                       one element
//   out_o    out  sorted_value, end_of_run, dropped    one sorted element
//
// Load takes one element per accepted beat; sort runs one round per element
// (an even and an odd compare-exchange phase each, all cells at once); emit
// shifts one element out per accepted beat. in_i is ready only while loading.
// Reset empties the chain and clears the count and the overflow flag.
// Output stalls hold the chain; beyond MAX_ELEMENTS elements are dropped.
// ----------------------------------------------------------------------------
`include "odd_even_transposition_sort_defines.svh"

module odd_even_transposition_sort import oets_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  oets_in_if.sink    in_i,
  oets_out_if.source out_o
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  count_t     count_q, count_d;
  count_t     rounds_q, rounds_d;
  logic       phase_q, phase_d;
  logic       overflow_q, overflow_d;

  logic       in_fire, out_fire, store;
  count_t     count_inc;
  cell_op_e   op;

  logic [MAX_ELEMENTS-1:0] cell_valid;
  value_t                  cell_value [MAX_ELEMENTS];

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_fire  = out_o.valid && out_o.ready;
  assign store     = (count_q != COUNT_W'(MAX_ELEMENTS));
  assign count_inc = count_q + COUNT_W'(store);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rounds_d   = rounds_q;
    phase_d    = phase_q;
    overflow_d = overflow_q;
    op         = CELL_HOLD;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          count_d = count_inc;
          if (store) begin
            op = CELL_LOAD;
          end else begin
            overflow_d = 1'b1;
          end
          if (in_i.is_last) begin
            state_d  = ST_SORT;
            rounds_d = count_inc;
            phase_d  = 1'b0;
          end
        end
      end
      ST_SORT: begin
        op      = CELL_CMP;
        phase_d = ~phase_q;
        if (phase_q) begin
          rounds_d = rounds_q - COUNT_W'(1);
          if (rounds_q == COUNT_W'(1)) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          op = CELL_UNLOAD;
          if (!cell_valid[1]) begin
            state_d    = ST_LOAD;
            count_d    = '0;
            overflow_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      rounds_q   <= '0;
      phase_q    <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rounds_q   <= rounds_d;
      phase_q    <= phase_d;
      overflow_q <= overflow_d;
    end
  end

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic       left_valid, right_valid;
    value_t     left_value, right_value;

    assign ctrl.op        = op;
    assign ctrl.use_right = (((i % 2) != 0) == phase_q);

    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
      assign left_value = (state_q == ST_LOAD) ? in_i.value : VALUE_MIN;
    end else begin : g_inner_left
      assign left_valid = cell_valid[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_value = VALUE_MIN;
    end else begin : g_inner_right
      assign right_valid = cell_valid[i+1];
      assign right_value = cell_value[i+1];
    end

    oets_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_valid_i (left_valid),
      .left_value_i (left_value),
      .right_valid_i(right_valid),
      .right_value_i(right_value),
      .valid_o      (cell_valid[i]),
      .value_o      (cell_value[i])
    );
  end

  assign in_i.ready         = (state_q == ST_LOAD);
  assign out_o.valid        = (state_q == ST_EMIT);
  assign out_o.sorted_value = cell_value[0];
  assign out_o.end_of_run   = !cell_valid[1];
  assign out_o.dropped      = overflow_q;

  `OETS_ASSERT(a_emit_has_head, clk_i, rst_ni, (state_q == ST_EMIT) |-> cell_valid[0])
  `OETS_ASSERT(a_sort_rounds_left, clk_i, rst_ni, (state_q == ST_SORT) |-> (rounds_q != '0))
  `OETS_ASSERT(a_run_end_resets, clk_i, rst_ni, (out_fire && out_o.end_of_run) |=> ((state_q == ST_LOAD) && (count_q == '0) && !cell_valid[0]))
  `OETS_ASSERT_NEVER(a_load_count_head, clk_i, rst_ni, (state_q == ST_LOAD) && ((count_q != '0) != cell_valid[0]))

endmodule

/* bench/oets_sort_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorter scoreboard
// Watches both channels, rebuilds each set from the input beats, sorts it
// by odd-even transposition and checks every output beat against it.
// ----------------------------------------------------------------------------
module oets_sort_checker import oets_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  oets_in_if          in_ch,
  oets_out_if         out_ch,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned results_o
);

  typedef struct packed {
    value_t sorted_value;
    logic   end_of_run;
    logic   dropped;
  } sorted_beat_t;

  value_t       held [MAX_ELEMENTS];
  int unsigned  held_count;
  logic         overflow;
  sorted_beat_t sorted_q [$];

  always @(posedge clk_i or negedge rst_ni) begin : track
    sorted_beat_t exp_beat;
    sorted_beat_t new_beat;
    value_t       tmp;
    int unsigned  round;
    int unsigned  i;
    if (!rst_ni) begin
      held_count = 0;
      overflow   = 1'b0;
      sorted_q.delete();
      errors_o   = 0;
      pending_o  = 0;
      results_o  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_o++;
        if (sorted_q.size() == 0) begin
          $error("unexpected output beat: sorted_value %0d", out_ch.sorted_value);
          errors_o++;
        end else begin
          exp_beat = sorted_q.pop_front();
          if (out_ch.sorted_value !== exp_beat.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d",
                   exp_beat.sorted_value, out_ch.sorted_value);
            errors_o++;
          end
          if (out_ch.end_of_run !== exp_beat.end_of_run) begin
            $error("end_of_run: expected %0b, got %0b",
                   exp_beat.end_of_run, out_ch.end_of_run);
            errors_o++;
          end
          if (out_ch.dropped !== exp_beat.dropped) begin
            $error("dropped: expected %0b, got %0b", exp_beat.dropped, out_ch.dropped);
            errors_o++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (held_count < MAX_ELEMENTS) begin
          held[held_count] = in_ch.value;
          held_count++;
        end else begin
          overflow = 1'b1;
        end
        if (in_ch.is_last) begin
          for (round = 0; round < held_count; round++) begin
            for (i = 0; i + 1 < held_count; i += 2) begin
              if (held[i] > held[i+1]) begin
                tmp       = held[i];
                held[i]   = held[i+1];
                held[i+1] = tmp;
              end
            end
            for (i = 1; i + 1 < held_count; i += 2) begin
              if (held[i] > held[i+1]) begin
                tmp       = held[i];
                held[i]   = held[i+1];
                held[i+1] = tmp;
              end
            end
          end
          for (i = 0; i < held_count; i++) begin
            new_beat.sorted_value = held[i];
            new_beat.end_of_run   = (i + 1 == held_count);
            new_beat.dropped      = overflow;
            sorted_q.push_back(new_beat);
          end
          held_count = 0;
          overflow   = 1'b0;
        end
      end
      pending_o = sorted_q.size();
    end
  end

endmodule

/* bench/odd_even_transposition_sort_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odd-even transposition sorter testbench
// Sends directed and random sets (single elements, extremes, duplicates,
// full and overflowing sets) under varying source gaps and sink stalls;
// the scoreboard checks every sorted beat.
// ----------------------------------------------------------------------------
module odd_even_transposition_sort_test;
  import oets_pkg::*;

  localparam value_t      VALUE_MAX    = ~VALUE_MIN;
  localparam int unsigned PHASE_ITEMS  = 115;
  localparam int unsigned LIMIT_CYCLES = 200000;

  logic clk_i;
  logic rst_ni;

  oets_in_if  in_ch ();
  oets_out_if out_ch ();

  int unsigned errors;
  int unsigned pending;
  int unsigned results;

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned cycle_count = 0;
  int unsigned items;
  int unsigned sets;
  int unsigned over_sets;
  int unsigned largest;

  odd_even_transposition_sort dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  oets_sort_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors_o  (errors),
    .pending_o (pending),
    .results_o (results)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $error("timeout after %0d cycles, %0d beats still expected", cycle_count, pending);
      $display("FAIL odd_even_transposition_sort");
      $finish;
    end
  end

  function automatic value_t pick_value();
    value_t v;
    case ($urandom_range(9))
      0:       v = VALUE_MIN;
      1:       v = VALUE_MAX;
      2:       v = $urandom_range(1) ? value_t'(0) : value_t'(-1);
      3, 4, 5: v = value_t'($signed($urandom_range(8)) - 4);
      default: v = value_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 62) begin
      n = $urandom_range(8, 1);
    end else if (r < 92) begin
      n = $urandom_range(40, 9);
    end else if (r < 96) begin
      n = MAX_ELEMENTS;
    end else begin
      n = $urandom_range(MAX_ELEMENTS + 4, MAX_ELEMENTS + 1);
    end
    return n;
  endfunction

  task automatic send_beat(input value_t v, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.is_last <= last;
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    items++;
  endtask

  task automatic send_list(input value_t vals[$]);
    foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
    sets++;
    if (vals.size() > largest) largest = vals.size();
  endtask

  task automatic send_random_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_beat(pick_value(), i == n - 1);
    sets++;
    if (n > MAX_ELEMENTS) over_sets++;
    if (n > largest) largest = n;
  endtask

  initial begin
    int unsigned phase_start;
    rst_ni        = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.value   <= '0;
    in_ch.is_last <= 1'b0;
    gap_pct       = 37;
    stall_pct     = 49;
    items         = 0;
    sets          = 0;
    over_sets     = 0;
    largest       = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_list('{VALUE_MIN});
    send_list('{VALUE_MAX});
    send_list('{VALUE_MAX, VALUE_MIN});
    send_list('{value_t'(0), value_t'(-1), value_t'(1)});
    send_list('{value_t'(5), value_t'(-3), value_t'(5), value_t'(-3), value_t'(5)});
    send_list('{value_t'(3), value_t'(2), value_t'(1), value_t'(0), value_t'(-1),
                value_t'(-2)});
    send_list('{VALUE_MIN, value_t'(-1), value_t'(0), value_t'(1), VALUE_MAX});

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          gap_pct   = 37;
          stall_pct = 49;
        end
        1: begin
          gap_pct   = 49;
          stall_pct = 37;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      phase_start = items;
      // one full set in the first phase and one overflowing set in the second
      if (phase == 0) send_random_set(MAX_ELEMENTS);
      if (phase == 1) send_random_set(MAX_ELEMENTS + 1);
      while (items - phase_start < PHASE_ITEMS) send_random_set(pick_size());
    end
    in_ch.valid <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (2 * MAX_ELEMENTS + 16) @(posedge clk_i);

    $display("sent %0d elements in %0d sets (%0d over capacity, largest %0d)",
             items, sets, over_sets, largest);
    $display("checked %0d sorted beats, %0d mismatches", results, errors);
    if (errors == 0) begin
      $display("PASS odd_even_transposition_sort");
    end else begin
      $display("FAIL odd_even_transposition_sort");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/oets_pkg.sv
rtl/oets_in_if.sv
rtl/oets_out_if.sv
rtl/oets_cell.sv
rtl/odd_even_transposition_sort.sv
bench/oets_sort_checker.sv
bench/odd_even_transposition_sort_test.sv
